>>> rtl/core/ihsd_pkg.sv
// Package for the H.264 intra slice detector.
// Holds the parse state, result types and codes shared by the parser and the top level.
// No dependencies.
package ihsd_pkg;

    // NAL unit types and slice types that matter here
    localparam logic [4:0] NAL_TYPE_NON_IDR = 5'd1;
    localparam logic [4:0] NAL_TYPE_IDR     = 5'd5;
    localparam logic [7:0] SLICE_TYPE_I     = 8'd2;
    localparam logic [7:0] SLICE_TYPE_I_ALL = 8'd7;

    // Register reset value, limit of the prefix counter and saturation value of the slice kind
    localparam logic [5:0] BIT_LIMIT_RESET = 6'd48;
    localparam logic [4:0] ZERO_RUN_MAX    = 5'd31;
    localparam logic [7:0] KIND_SAT        = 8'd255;

    typedef enum logic [2:0] {
        OUT_IDR   = 3'd0,
        OUT_OTHER = 3'd1,
        OUT_SLICE = 3'd2,
        OUT_OVER  = 3'd3,
        OUT_TRUNC = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PARSE = 2'd1
    } phase_t;

    // Exp-Golomb parse state; only the low 8 suffix bits ever reach the result
    typedef struct packed {
        phase_t     phase;
        logic [4:0] held_type;
        logic [5:0] bits_used;
        logic       code_index;
        logic [4:0] zero_run;
        logic       in_suffix;
        logic [4:0] suffix_left;
        logic [7:0] suffix_value;
    } parse_state_t;

    typedef struct packed {
        logic       is_intra;
        outcome_t   outcome;
        logic [4:0] unit_type;
        logic [7:0] slice_kind;
    } result_t;

endpackage

>>> rtl/core/ihsd_if.sv
// Valid/ready channel interfaces for the intra slice detector.
// ihsd_in_if carries NAL unit bytes, ihsd_out_if carries verdicts. No dependencies.
interface ihsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                    output ready);
endinterface

interface ihsd_out_if;
    logic       valid;
    logic       ready;
    logic       is_intra;
    logic [2:0] outcome;
    logic [4:0] unit_type;
    logic [7:0] slice_kind;

    modport source (output valid, output is_intra, output outcome, output unit_type,
                    output slice_kind, input ready);
    modport sink   (input valid, input is_intra, input outcome, input unit_type,
                    input slice_kind, output ready);
endinterface

>>> rtl/core/ihsd_byte_parser.sv
// One-byte step of the slice header parser: header decode and eight Exp-Golomb bit steps.
// Purely combinational; depends on ihsd_pkg.
module ihsd_byte_parser (
    input  ihsd_pkg::parse_state_t cur_state,
    input  logic [5:0]             bit_limit,
    input  logic [7:0]             data_byte,
    input  logic                   first_byte,
    input  logic                   last_byte,
    output ihsd_pkg::parse_state_t next_state,
    output logic                   res_valid,
    output ihsd_pkg::result_t      result
);
    import ihsd_pkg::*;

    // Header handling, then the unrolled bit walk for a type 1 unit
    always_comb
    begin
        parse_state_t st;
        logic         bit_val;
        logic         code_done;
        logic         decided;
        logic [8:0]   kind_sum;
        logic [7:0]   kind;

        st        = cur_state;
        decided   = 1'b0;
        code_done = 1'b0;
        bit_val   = 1'b0;
        kind_sum  = 9'd0;
        kind      = 8'd0;
        res_valid = 1'b0;
        result    = '{is_intra: 1'b0, outcome: OUT_OTHER, unit_type: 5'd0, slice_kind: 8'd0};

        if (first_byte)
        begin
            st.held_type = data_byte[4:0];
            st.phase     = PH_IDLE;
            result.unit_type = data_byte[4:0];
            if (data_byte[4:0] == NAL_TYPE_IDR)
            begin
                res_valid       = 1'b1;
                result.is_intra = 1'b1;
                result.outcome  = OUT_IDR;
            end
            else if (data_byte[4:0] != NAL_TYPE_NON_IDR)
            begin
                res_valid      = 1'b1;
                result.outcome = OUT_OTHER;
            end
            else if (last_byte)
            begin
                res_valid      = 1'b1;
                result.outcome = OUT_TRUNC;
            end
            else
            begin
                st.phase        = PH_PARSE;
                st.bits_used    = 6'd0;
                st.code_index   = 1'b0;
                st.zero_run     = 5'd0;
                st.in_suffix    = 1'b0;
                st.suffix_left  = 5'd0;
                st.suffix_value = 8'd0;
            end
        end
        else if (cur_state.phase == PH_PARSE)
        begin
            result.unit_type = cur_state.held_type;
            for (int i = 7; i >= 0; i--)
            begin
                bit_val   = data_byte[3'(i)];
                code_done = 1'b0;
                if (!decided)
                begin
                    if (st.bits_used >= bit_limit)
                    begin
                        decided        = 1'b1;
                        result.outcome = OUT_OVER;
                    end
                    else
                    begin
                        st.bits_used = st.bits_used + 6'd1;
                        if (!st.in_suffix)
                        begin
                            if (!bit_val)
                            begin
                                if (st.zero_run == ZERO_RUN_MAX)
                                begin
                                    decided        = 1'b1;
                                    result.outcome = OUT_OVER;
                                end
                                else
                                begin
                                    st.zero_run = st.zero_run + 5'd1;
                                end
                            end
                            else if (st.zero_run == 5'd0)
                            begin
                                code_done = 1'b1;
                            end
                            else
                            begin
                                st.in_suffix    = 1'b1;
                                st.suffix_left  = st.zero_run;
                                st.suffix_value = 8'd0;
                            end
                        end
                        else
                        begin
                            st.suffix_value = {st.suffix_value[6:0], bit_val};
                            st.suffix_left  = st.suffix_left - 5'd1;
                            code_done       = (st.suffix_left == 5'd0);
                        end

                        // first code done: start slice type; second: decide
                        if (code_done && !st.code_index)
                        begin
                            st.code_index   = 1'b1;
                            st.zero_run     = 5'd0;
                            st.in_suffix    = 1'b0;
                            st.suffix_left  = 5'd0;
                            st.suffix_value = 8'd0;
                        end
                        else if (code_done)
                        begin
                            decided = 1'b1;
                            if (st.zero_run >= 5'd8)
                            begin
                                kind = KIND_SAT;
                            end
                            else
                            begin
                                kind_sum = ((9'd1 << st.zero_run[2:0]) - 9'd1)
                                           + {1'b0, st.suffix_value};
                                kind     = kind_sum[8] ? KIND_SAT : kind_sum[7:0];
                            end
                            result.outcome    = OUT_SLICE;
                            result.slice_kind = kind;
                            result.is_intra   = (kind == SLICE_TYPE_I) ||
                                                (kind == SLICE_TYPE_I_ALL);
                        end
                    end
                end
            end

            if (!decided && last_byte)
            begin
                decided        = 1'b1;
                result.outcome = OUT_TRUNC;
            end
            if (decided)
            begin
                res_valid = 1'b1;
                st.phase  = PH_IDLE;
            end
        end

        next_state = st;
    end

endmodule

>>> rtl/core/h264_intra_slice_detector_core.sv
// Verdict path: a transferred byte is held in the input register and its verdict
// is registered in the result register (two register stages); input waits while it is full.
// Throughput: one byte per cycle unless stalled; eight bit steps unrolled in one stage.
// Reset (rst_n, asynchronous, active low): idle, no verdict pending, bit_limit back to 48.
// Depends on ihsd_pkg, ihsd_if and ihsd_byte_parser.
module h264_intra_slice_detector_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [5:0]       cfg_wr_data,
    ihsd_in_if.sink          bytes,
    ihsd_out_if.source       verdict
);
    import ihsd_pkg::*;

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_first_reg;
    logic          s1_last_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic [5:0]    limit_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    result_t       out_result_reg;
    logic          res_valid;
    result_t       res;
    logic          advance;

    // Input stage moves on when the result register is free or being emptied
    assign advance     = s1_valid_reg && (!out_valid_reg || verdict.ready);
    assign bytes.ready = !s1_valid_reg || advance;

    ihsd_byte_parser u_parser (
        .cur_state  (state_reg),
        .bit_limit  (limit_reg),
        .data_byte  (s1_byte_reg),
        .first_byte (s1_first_reg),
        .last_byte  (s1_last_reg),
        .next_state (state_next),
        .res_valid  (res_valid),
        .result     (res)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= BIT_LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (bytes.ready)
            s1_valid_reg <= bytes.valid;
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            s1_byte_reg  <= bytes.data_byte;
            s1_first_reg <= bytes.first_byte;
            s1_last_reg  <= bytes.last_byte;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{phase: PH_IDLE, held_type: 5'd0, bits_used: 6'd0,
                           code_index: 1'b0, zero_run: 5'd0, in_suffix: 1'b0,
                           suffix_left: 5'd0, suffix_value: 8'd0};
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !verdict.ready;
        if (advance && res_valid)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_result_reg <= res;
    end

    assign verdict.valid      = out_valid_reg;
    assign verdict.is_intra   = out_result_reg.is_intra;
    assign verdict.outcome    = out_result_reg.outcome;
    assign verdict.unit_type  = out_result_reg.unit_type;
    assign verdict.slice_kind = out_result_reg.slice_kind;

    // Checks
    a_kind_only_on_slice: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_result_reg.outcome != OUT_SLICE)
            |-> out_result_reg.slice_kind == 8'd0)
        else $error("slice_kind set without a decoded slice type");

    a_intra_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.is_intra
            |-> (out_result_reg.outcome == OUT_IDR) || (out_result_reg.outcome == OUT_SLICE))
        else $error("intra verdict with wrong outcome");

    a_parse_type: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PARSE |-> state_reg.held_type == NAL_TYPE_NON_IDR)
        else $error("parsing a unit that is not type 1");

    a_suffix_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_PARSE) && state_reg.in_suffix
            |-> (state_reg.suffix_left != 5'd0) &&
                (state_reg.suffix_left <= state_reg.zero_run))
        else $error("suffix count out of range");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg || !out_valid_reg |-> bytes.ready)
        else $error("input stalled with free result register");

endmodule

>>> tb/tb_h264_intra_slice_detector_core.sv
`timescale 1ns / 100ps
// Testbench for h264_intra_slice_detector_core: streams NAL unit bytes over the byte channel
// and checks every verdict against a bit-serial Exp-Golomb slice header predictor.
// Depends on ihsd_pkg, ihsd_if and the core RTL.
module tb_h264_intra_slice_detector_core;
    import ihsd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } nal_byte_t;

    localparam int DRAIN_CYCLES = 6;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [5:0] cfg_wr_data;

    ihsd_in_if  bytes_if ();
    ihsd_out_if verdict_if ();

    h264_intra_slice_detector_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .bytes       (bytes_if),
        .verdict     (verdict_if)
    );

    // Stimulus and expectation stores
    nal_byte_t pending_bytes [$];
    result_t   verdicts_due [$];
    bit        hdr_stream [$];
    int        mismatches = 0;

    // Predictor copy of the parser state and the limit register
    phase_t     unit_phase;
    logic [4:0] unit_type;
    logic [5:0] hdr_bits;
    logic       second_code;
    logic [4:0] zero_count;
    logic       reading_suffix;
    logic [4:0] suffix_todo;
    logic [7:0] suffix_bits;
    logic [5:0] limit_bits = BIT_LIMIT_RESET;

    // Sender burst and receiver stall bookkeeping
    int unsigned burst_left;
    int unsigned gap_left;
    logic [9:0]  stall_tick;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void restart_code();
        zero_count     = '0;
        reading_suffix = 1'b0;
        suffix_todo    = '0;
        suffix_bits    = '0;
    endfunction

    // Consume one slice header bit; returns 1 once the unit is decided
    function automatic bit golomb_bit(input logic bv, output outcome_t oc,
                                      output logic [7:0] kind);
        bit         code_done;
        logic [8:0] wide;
        code_done = 1'b0;
        kind      = '0;
        oc        = OUT_SLICE;
        // limit checked before each bit: the total can only grow
        if (hdr_bits >= limit_bits)
        begin
            oc = OUT_OVER;
            return 1'b1;
        end
        hdr_bits = hdr_bits + 6'd1;
        if (!reading_suffix)
        begin
            if (!bv)
            begin
                // prefix longer than 31 zeros can never fit
                if (zero_count >= ZERO_RUN_MAX)
                begin
                    oc = OUT_OVER;
                    return 1'b1;
                end
                zero_count = zero_count + 5'd1;
            end
            else if (zero_count == 0)
                code_done = 1'b1;
            else
            begin
                reading_suffix = 1'b1;
                suffix_todo    = zero_count;
                suffix_bits    = '0;
            end
        end
        else
        begin
            suffix_bits = {suffix_bits[6:0], bv};
            suffix_todo = suffix_todo - 5'd1;
            if (suffix_todo == 0)
                code_done = 1'b1;
        end
        if (!code_done)
            return 1'b0;
        // first code is first_mb_in_slice, only its length matters
        if (!second_code)
        begin
            second_code = 1'b1;
            restart_code();
            return 1'b0;
        end
        if (zero_count >= 5'd8)
            kind = KIND_SAT;
        else
        begin
            wide = ((9'd1 << zero_count) - 9'd1) + {1'b0, suffix_bits};
            kind = (wide > 9'd255) ? KIND_SAT : wide[7:0];
        end
        return 1'b1;
    endfunction

    // Expected verdict for one transferred byte; returns 1 if one is due
    function automatic bit predict_verdict(input nal_byte_t item, output result_t res);
        outcome_t   oc;
        logic [7:0] kind;
        res = '0;
        if (item.first)
        begin
            // a new header always drops an unfinished unit silently
            unit_type     = item.data[4:0];
            unit_phase    = PH_IDLE;
            res.unit_type = item.data[4:0];
            if (unit_type == NAL_TYPE_IDR)
            begin
                res.is_intra = 1'b1;
                res.outcome  = OUT_IDR;
                return 1'b1;
            end
            if (unit_type != NAL_TYPE_NON_IDR)
            begin
                res.outcome = OUT_OTHER;
                return 1'b1;
            end
            if (item.last)
            begin
                res.outcome = OUT_TRUNC;
                return 1'b1;
            end
            unit_phase  = PH_PARSE;
            hdr_bits    = '0;
            second_code = 1'b0;
            restart_code();
            return 1'b0;
        end
        if (unit_phase != PH_PARSE)
            return 1'b0;
        res.unit_type = unit_type;
        for (int i = 7; i >= 0; i--)
        begin
            if (golomb_bit(item.data[i], oc, kind))
            begin
                unit_phase  = PH_IDLE;
                res.outcome = oc;
                if (oc == OUT_SLICE)
                begin
                    res.slice_kind = kind;
                    res.is_intra   = (kind == SLICE_TYPE_I) || (kind == SLICE_TYPE_I_ALL);
                end
                return 1'b1;
            end
        end
        if (item.last)
        begin
            unit_phase  = PH_IDLE;
            res.outcome = OUT_TRUNC;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_byte(input logic [7:0] d, input logic f, input logic l);
        nal_byte_t item;
        item.data  = d;
        item.first = f;
        item.last  = l;
        pending_bytes.insert(pending_bytes.size(), item);
    endfunction

    // Append the unsigned Exp-Golomb code of v to the header bit stream
    function automatic void put_golomb(input int unsigned v);
        int unsigned code;
        int          n;
        code = v + 1;
        n    = 0;
        while ((code >> (n + 1)) != 0)
            n++;
        repeat (n) hdr_stream.insert(hdr_stream.size(), 1'b0);
        for (int i = n; i >= 0; i--)
            hdr_stream.insert(hdr_stream.size(), code[i]);
    endfunction

    // Type 1 unit with two codes or a long zero run, random tail; sometimes cut short or left open
    function automatic void queue_slice_unit();
        int unsigned pick;
        int unsigned kind_val;
        int unsigned nbytes;
        int unsigned keep;
        bit          abandon;
        logic [7:0]  b;
        hdr_stream.delete();
        pick = $urandom_range(0, 99);
        if (pick < 5)
            repeat ($urandom_range(24, 40)) hdr_stream.insert(hdr_stream.size(), 1'b0);
        else
        begin
            put_golomb((pick < 75) ? $urandom_range(0, 20) : $urandom_range(21, 8000));
            pick = $urandom_range(0, 99);
            if (pick < 35)
                kind_val = 32'($urandom_range(0, 1) ? SLICE_TYPE_I : SLICE_TYPE_I_ALL);
            else if (pick < 85)
                kind_val = $urandom_range(0, 9);
            else
                kind_val = $urandom_range(10, 700);
            put_golomb(kind_val);
        end
        nbytes = (hdr_stream.size() + $urandom_range(0, 12) + 7) / 8 + $urandom_range(0, 2);
        while (hdr_stream.size() < nbytes * 8)
            hdr_stream.insert(hdr_stream.size(), 1'($urandom_range(0, 1)));
        keep    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nbytes - 1) : nbytes;
        abandon = ($urandom_range(0, 19) == 0);
        push_byte({3'($urandom_range(0, 7)), NAL_TYPE_NON_IDR}, 1'b1, !abandon && keep == 0);
        for (int k = 0; k < keep; k++)
        begin
            for (int j = 0; j < 8; j++)
                b[7 - j] = hdr_stream[8 * k + j];
            push_byte(b, 1'b0, !abandon && k == keep - 1);
        end
    endfunction

    // Unit of any other type, IDR favoured, with a short random body
    function automatic void queue_other_unit();
        int unsigned t;
        int unsigned body;
        do
            t = $urandom_range(0, 31);
        while (t == NAL_TYPE_NON_IDR);
        if ($urandom_range(0, 2) == 0)
            t = 32'(NAL_TYPE_IDR);
        body = $urandom_range(0, 3);
        push_byte({3'($urandom_range(0, 7)), 5'(t)}, 1'b1, body == 0);
        for (int k = 1; k <= body; k++)
            push_byte(8'($urandom_range(0, 255)), 1'b0, k == body);
    endfunction

    function automatic void queue_noise();
        repeat ($urandom_range(1, 4))
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                      1'($urandom_range(0, 1)));
    endfunction

    function automatic void queue_random(input int unsigned n);
        int unsigned goal;
        int unsigned pick;
        goal = pending_bytes.size() + n;
        while (pending_bytes.size() < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                queue_slice_unit();
            else if (pick < 82)
                queue_other_unit();
            else
                queue_noise();
        end
    endfunction

    // Directed cases, run at the reset limit of 48
    function automatic void queue_directed();
        push_byte(8'h65, 1'b1, 1'b1);   // IDR header
        push_byte(8'hFF, 1'b1, 1'b1);   // type 31, all header bits set
        push_byte(8'h41, 1'b1, 1'b1);   // type 1 header that is also the last byte
        push_byte(8'h12, 1'b0, 1'b0);   // stray byte while idle
        // slice type 2, then a byte after the decision
        push_byte(8'h41, 1'b1, 1'b0);
        push_byte(8'hB0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        // slice type 7
        push_byte(8'h21, 1'b1, 1'b0);
        push_byte(8'h88, 1'b0, 1'b1);
        // new header while still parsing
        push_byte(8'h41, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h05, 1'b1, 1'b0);
        // unit ends mid-code
        push_byte(8'h41, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        // slice type saturates at 255
        push_byte(8'h01, 1'b1, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);
        // zero run past 31 bits
        push_byte(8'h41, 1'b1, 1'b0);
        repeat (4) push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
    endfunction

    // Pause the sender until every verdict is in and the core has settled
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || bytes_if.valid || verdicts_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [5:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        limit_bits   = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Main sequence: reset, directed bytes, then random phases over several limits
    initial
    begin
        logic [5:0] limit_plan [5];
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        limit_plan = '{6'd63, 6'd1, 6'($urandom_range(2, 62)), 6'($urandom_range(2, 62)),
                       BIT_LIMIT_RESET};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        queue_directed();
        queue_random(60);
        foreach (limit_plan[p])
        begin
            wait_for_drain();
            write_limit(limit_plan[p]);
            @(negedge clk);
            queue_random(140);
        end
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_h264_intra_slice_detector_core: PASS");
        else
            $display("tb_h264_intra_slice_detector_core: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("tb_h264_intra_slice_detector_core: FAIL");
        $finish;
    end

    // Byte driver: predicts on each transfer, then loads the next byte in bursts
    always @(posedge clk or negedge rst_n)
    begin
        nal_byte_t cur;
        result_t   due;
        logic      next_valid;
        if (!rst_n)
        begin
            bytes_if.valid      <= 1'b0;
            bytes_if.data_byte  <= '0;
            bytes_if.first_byte <= 1'b0;
            bytes_if.last_byte  <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
            unit_phase  = PH_IDLE;
            unit_type   = '0;
            hdr_bits    = '0;
            second_code = 1'b0;
            restart_code();
        end
        else
        begin
            next_valid = bytes_if.valid;
            if (bytes_if.valid && bytes_if.ready)
            begin
                cur.data  = bytes_if.data_byte;
                cur.first = bytes_if.first_byte;
                cur.last  = bytes_if.last_byte;
                if (predict_verdict(cur, due))
                    verdicts_due.insert(verdicts_due.size(), due);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (pending_bytes.size() != 0)
                begin
                    cur = pending_bytes.pop_front();
                    bytes_if.data_byte  <= cur.data;
                    bytes_if.first_byte <= cur.first;
                    bytes_if.last_byte  <= cur.last;
                    next_valid = 1'b1;
                    // end of burst: pick a gap (sometimes none) and the next burst length
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
            bytes_if.valid <= next_valid;
        end
    end

    // Verdict monitor: checks each transfer, ready follows a rotating stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            verdict_if.ready <= 1'b0;
            stall_tick = '0;
        end
        else
        begin
            if (verdict_if.valid && verdict_if.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("unexpected verdict: outcome %0d unit_type %0d",
                           verdict_if.outcome, verdict_if.unit_type);
                    mismatches++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (verdict_if.is_intra !== want.is_intra)
                    begin
                        $error("is_intra: expected %0d, got %0d",
                               want.is_intra, verdict_if.is_intra);
                        mismatches++;
                    end
                    if (verdict_if.outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, got %0d",
                               want.outcome, verdict_if.outcome);
                        mismatches++;
                    end
                    if (verdict_if.unit_type !== want.unit_type)
                    begin
                        $error("unit_type: expected %0d, got %0d",
                               want.unit_type, verdict_if.unit_type);
                        mismatches++;
                    end
                    if (verdict_if.slice_kind !== want.slice_kind)
                    begin
                        $error("slice_kind: expected %0d, got %0d",
                               want.slice_kind, verdict_if.slice_kind);
                        mismatches++;
                    end
                end
            end
            // four stall modes, rotating with stall_tick bits 9:8: none, random, sparse, long runs
            stall_tick = stall_tick + 10'd1;
            case (stall_tick[9:8])
                2'd0:    verdict_if.ready <= 1'b1;
                2'd1:    verdict_if.ready <= 1'($urandom_range(0, 1));
                2'd2:    verdict_if.ready <= (stall_tick[2:0] == 3'd0);
                default: verdict_if.ready <= stall_tick[4];
            endcase
        end
    end

endmodule

>>> filelist.f
rtl/core/ihsd_pkg.sv
rtl/core/ihsd_if.sv
rtl/core/ihsd_byte_parser.sv
rtl/core/h264_intra_slice_detector_core.sv
tb/tb_h264_intra_slice_detector_core.sv
